[sv/assert_macros.svh]
// assertion macros used by the checker file cftp_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// when ante holds, cons must hold at the same edge
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[sv/cftp_pkg.sv]
// shared constants for the circle-through-three-points block
// no dependencies
package cftp_pkg;

  localparam int DefCoordWidth = 20;

  // edges from the edge that accepts a command to the edge that takes its result
  function automatic int cftp_latency(int cw);
    return 3 * cw + 16;
  endfunction

endpackage

[sv/cftp_div.sv]
// pipelined restoring divider, one quotient bit per stage, magnitudes only
// caller guarantees num_i < den_i * 2**QB; no package use
module cftp_div #(
  parameter int NW = 65,
  parameter int DW = 44,
  parameter int QB = 46
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o
);

  localparam int WW = (NW > DW + QB) ? NW : DW + QB;

  logic [WW-1:0] rem_q [QB];
  logic [DW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int Bit = QB - 1 - s;
    logic [WW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [WW-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = WW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      trial = WW'(den_in) << Bit;
      ge    = rem_in >= trial;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? rem_in - trial : rem_in;
      den_q[s] <= den_in;
      quo_q[s] <= ge ? (quo_in | (QB'(1) << Bit)) : quo_in;
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

[sv/cftp_sqrt.sv]
// pipelined digit-by-digit integer square root, one result bit per stage
// floor root of a 2*RW bit radicand; no package use
module cftp_sqrt #(
  parameter int RW = 20
) (
  input  logic            clk_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW-1:0]   root_o
);

  localparam int TW = 2 * RW + 1;

  logic [2*RW-1:0] rem_q [RW];
  logic [RW-1:0]   res_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int Bit = RW - 1 - s;
    logic [2*RW-1:0] rem_in;
    logic [RW-1:0]   res_in;
    logic [TW-1:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign res_in = res_q[s-1];
    end

    // rem = rad - res^2; next bit fits when rem >= (2*res + 2^b) * 2^b
    always_comb begin
      trial = (TW'(res_in) << (Bit + 1)) + (TW'(1) << (2 * Bit));
      ge    = TW'(rem_in) >= trial;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? rem_in - trial[2*RW-1:0] : rem_in;
      res_q[s] <= ge ? (res_in | (RW'(1) << Bit)) : res_in;
    end
  end

  assign root_o = res_q[RW-1];

endmodule

[sv/circle_from_three_points.sv]
// channel | dir | handshake          | payload
// command | in  | start_i, busy_o    | first_x_i .. third_y_i (signed)
// result  | out | done_o (1 cycle)   | center_x_o, center_y_o, radius_o, collinear_o, saturated_o
//
// one transaction per cycle; between each command and its result lie the 2*COORD_WIDTH+6 stage
// divider and the COORD_WIDTH stage root
// busy_o stays low: every stage advances every cycle, nothing is stalled or dropped
// the receiver cannot hold results off; done_o marks each result for exactly one cycle
// reset clears the valid bits of all stages and col_q, sat_q; datapath registers are not reset
// depends on cftp_pkg, cftp_div, cftp_sqrt
module circle_from_three_points
  import cftp_pkg::*;
#(
  parameter int COORD_WIDTH = DefCoordWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  input  logic signed [COORD_WIDTH-1:0] third_x_i,
  input  logic signed [COORD_WIDTH-1:0] third_y_i,
  output logic                          done_o,
  output logic        [COORD_WIDTH-1:0] center_x_o,
  output logic        [COORD_WIDTH-1:0] center_y_o,
  output logic        [COORD_WIDTH-1:0] radius_o,
  output logic                          collinear_o,
  output logic                          saturated_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;           // coordinate differences and sums
  localparam int PW   = 2 * DW + 1;       // f and g
  localparam int QW   = 2 * CW + 1;       // x1*x2+y1*y2 and x2*y1-x1*y2
  localparam int HW   = PW + DW + 1;      // numerators of h and k
  localparam int EPW  = PW + CW + 1;      // partial products of the e numerator
  localparam int NEW  = PW + QW + 1;      // numerator of e
  localparam int DHW  = PW + 1;           // 2*md
  localparam int QB   = 2 * CW + 6;       // quotient bits kept by the dividers
  localparam int OWH  = (HW > DHW + QB) ? HW : DHW + QB;
  localparam int OWE  = (NEW > PW + QB) ? NEW : PW + QB;
  localparam int SMW  = CW + 2;           // |h|, |k| below the big-center bound
  localparam int SQW  = 2 * SMW;
  localparam int EVW  = QB + 1;           // e, signed
  localparam int SW   = QB + 2;           // h^2 + k^2 - e, signed

  typedef struct packed {
    logic ovf_h;
    logic ovf_k;
    logic ovf_e;
    logic sign_e;
    logic col;
  } div_side_t;

  typedef struct packed {
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic          sat_hk;
    logic          r_sat;
    logic          r_zero;
    logic          col;
  } root_side_t;

  // the pipeline never stalls
  assign busy_o = 1'b0;

  // valid bits, one per stage
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, va_q, vb_q, vc_q;
  logic vd_q [QB];
  logic vr_q [CW];

  // stage 1: differences and sums of the coordinates
  logic signed [DW-1:0] a_q, b_q, c_q, d_q, e1_q, f1_q, sx_q, sy_q;
  logic signed [CW-1:0] x1_q, x2_q, y1_q, y2_q;

  // stage 2: products
  logic signed [2*DW-1:0] ab_q, cd_q, ae_q, fc_q;
  logic signed [2*CW-1:0] xx_q, yy_q, xy21_q, xy12_q;
  logic signed [DW-1:0]   e1_2q, f1_2q, sx_2q, sy_2q;

  // stage 3: f, g and the two quadratic terms
  logic signed [PW-1:0] f_q, g_q;
  logic signed [QW-1:0] q1_q, q2_q;
  logic signed [DW-1:0] e1_3q, f1_3q, sx_3q, sy_3q;

  // stage 4: slope ratio mn/md and its products
  logic                 col4;
  logic signed [PW-1:0] mn4, md4;
  logic signed [CW:0]   q1_hi, q1_lo, q2_hi, q2_lo;
  logic signed [PW+DW-1:0] ph1_q, ph2_q, pk1_q, pk2_q;
  logic signed [EPW-1:0]   pe1_q, pe2_q, pe3_q, pe4_q;
  logic signed [PW-1:0]    md_4q;
  logic                    col_4q;

  // stage 5: numerators (h and k up to sign, which the result drops)
  logic signed [NEW-1:0] ne_hi, ne5;
  logic signed [HW-1:0]  nh_q, nk_q;
  logic signed [NEW-1:0] ne_q;
  logic signed [PW-1:0]  md_5q;
  logic                  col_5q;

  // stage 6: magnitudes and range checks ahead of the dividers
  logic [HW-1:0]  nh_mag, nk_mag;
  logic [NEW-1:0] ne_mag;
  logic [PW-1:0]  md_mag;
  logic [DHW-1:0] den2_mag;
  div_side_t      side6;
  logic [HW-1:0]  hnum_q, knum_q;
  logic [NEW-1:0] enum_q;
  logic [DHW-1:0] hden_q;
  logic [PW-1:0]  eden_q;
  div_side_t      side6_q;
  div_side_t      sided_q [QB];

  logic [QB-1:0] qh, qk, qe;

  // stage a: clip the center, bound h and k for squaring, sign e
  div_side_t            sda;
  logic                 big_h, big_k, sat_h, sat_k;
  logic [CW-1:0]        cx_q, cy_q;
  logic                 sat_hk_aq, big_aq, ovf_e_aq, sign_e_aq, col_aq;
  logic [SMW-1:0]       hs_q, ks_q;
  logic signed [EVW-1:0] ev_q;

  // stage b: squares
  logic [SQW-1:0]        hh_q, kk_q;
  logic [CW-1:0]         cx_bq, cy_bq;
  logic                  sat_hk_bq, big_bq, ovf_e_bq, sign_e_bq, col_bq;
  logic signed [EVW-1:0] ev_bq;

  // stage c: radicand and radius case
  logic signed [SW-1:0] s_c;
  logic                 s_pos, s_big, r_sat_c, r_zero_c;
  logic [2*CW-1:0]      rad_q;
  root_side_t           side_c_q;
  root_side_t           sider_q [CW];
  root_side_t           sro;
  logic [CW-1:0]        root;

  // output registers
  logic          done_q, col_q, sat_q;
  logic [CW-1:0] cx_out_q, cy_out_q, r_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      done_q <= 1'b0;
      col_q  <= 1'b0;
      sat_q  <= 1'b0;
      for (int i = 0; i < QB; i++) vd_q[i] <= 1'b0;
      for (int i = 0; i < CW; i++) vr_q[i] <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vd_q[0] <= v6_q;
      for (int i = 1; i < QB; i++) vd_q[i] <= vd_q[i-1];
      va_q <= vd_q[QB-1];
      vb_q <= va_q;
      vc_q <= vb_q;
      vr_q[0] <= vc_q;
      for (int i = 1; i < CW; i++) vr_q[i] <= vr_q[i-1];
      done_q <= vr_q[CW-1];
      col_q  <= vr_q[CW-1] & sro.col;
      sat_q  <= vr_q[CW-1] & (sro.sat_hk | sro.r_sat);
    end
  end

  // stage 4 slope select: collinear points force m to zero
  always_comb begin
    col4  = (g_q == '0);
    mn4   = col4 ? '0 : f_q;
    md4   = col4 ? {{(PW-1){1'b0}}, 1'b1} : g_q;
    q1_hi = signed'(q1_q[QW-1:CW]);
    q1_lo = signed'({1'b0, q1_q[CW-1:0]});
    q2_hi = signed'(q2_q[QW-1:CW]);
    q2_lo = signed'({1'b0, q2_q[CW-1:0]});
  end

  // stage 5 e numerator from its split partial products
  always_comb begin
    ne_hi = NEW'(pe1_q) + NEW'(pe3_q);
    ne5   = (ne_hi <<< CW) + NEW'(pe2_q) + NEW'(pe4_q);
  end

  // stage 6 magnitudes; a quotient beyond QB bits is only flagged
  always_comb begin
    nh_mag   = nh_q[HW-1] ? -nh_q : nh_q;
    nk_mag   = nk_q[HW-1] ? -nk_q : nk_q;
    ne_mag   = ne_q[NEW-1] ? -ne_q : ne_q;
    md_mag   = md_5q[PW-1] ? -md_5q : md_5q;
    den2_mag = {md_mag, 1'b0};
    side6.ovf_h  = OWH'(nh_mag) >= (OWH'(den2_mag) << QB);
    side6.ovf_k  = OWH'(nk_mag) >= (OWH'(den2_mag) << QB);
    side6.ovf_e  = OWE'(ne_mag) >= (OWE'(md_mag) << QB);
    side6.sign_e = ne_q[NEW-1] ^ md_5q[PW-1];
    side6.col    = col_5q;
  end

  // stage a: a center of 2^(CW+2) or more always saturates the radius too
  always_comb begin
    sda   = sided_q[QB-1];
    big_h = sda.ovf_h | (qh[QB-1:SMW] != '0);
    big_k = sda.ovf_k | (qk[QB-1:SMW] != '0);
    sat_h = sda.ovf_h | (qh[QB-1:CW] != '0);
    sat_k = sda.ovf_k | (qk[QB-1:CW] != '0);
  end

  // stage c: radius case; a huge e decides the sign of the radicand alone
  always_comb begin
    s_c      = signed'(SW'(hh_q)) + signed'(SW'(kk_q)) - SW'(ev_bq);
    s_pos    = !s_c[SW-1] && (s_c != '0);
    s_big    = !s_c[SW-1] && (s_c[SW-2:2*CW] != '0);
    r_sat_c  = big_bq | (ovf_e_bq & sign_e_bq) | (!ovf_e_bq & s_big);
    r_zero_c = !big_bq & ((ovf_e_bq & !sign_e_bq) | (!ovf_e_bq & !s_pos));
  end

  assign sro = sider_q[CW-1];

  always_ff @(posedge clk_i) begin
    // stage 1
    a_q  <= third_x_i - first_x_i;
    b_q  <= third_x_i - second_x_i;
    c_q  <= third_y_i - first_y_i;
    d_q  <= third_y_i - second_y_i;
    e1_q <= first_y_i - second_y_i;
    f1_q <= second_x_i - first_x_i;
    sx_q <= first_x_i + second_x_i;
    sy_q <= first_y_i + second_y_i;
    x1_q <= first_x_i;
    x2_q <= second_x_i;
    y1_q <= first_y_i;
    y2_q <= second_y_i;
    // stage 2
    ab_q   <= a_q * b_q;
    cd_q   <= c_q * d_q;
    ae_q   <= a_q * e1_q;
    fc_q   <= f1_q * c_q;
    xx_q   <= x1_q * x2_q;
    yy_q   <= y1_q * y2_q;
    xy21_q <= x2_q * y1_q;
    xy12_q <= x1_q * y2_q;
    e1_2q  <= e1_q;
    f1_2q  <= f1_q;
    sx_2q  <= sx_q;
    sy_2q  <= sy_q;
    // stage 3
    f_q   <= ab_q + cd_q;
    g_q   <= ae_q + fc_q;
    q1_q  <= xx_q + yy_q;
    q2_q  <= xy21_q - xy12_q;
    e1_3q <= e1_2q;
    f1_3q <= f1_2q;
    sx_3q <= sx_2q;
    sy_3q <= sy_2q;
    // stage 4
    ph1_q  <= mn4 * e1_3q;
    ph2_q  <= md4 * sx_3q;
    pk1_q  <= mn4 * f1_3q;
    pk2_q  <= md4 * sy_3q;
    pe1_q  <= md4 * q1_hi;
    pe2_q  <= md4 * q1_lo;
    pe3_q  <= mn4 * q2_hi;
    pe4_q  <= mn4 * q2_lo;
    md_4q  <= md4;
    col_4q <= col4;
    // stage 5
    nh_q   <= ph1_q + ph2_q;
    nk_q   <= pk1_q + pk2_q;
    ne_q   <= ne5;
    md_5q  <= md_4q;
    col_5q <= col_4q;
    // stage 6
    hnum_q  <= nh_mag;
    knum_q  <= nk_mag;
    enum_q  <= ne_mag;
    hden_q  <= den2_mag;
    eden_q  <= md_mag;
    side6_q <= side6;
    // flags ride beside the divider stages
    sided_q[0] <= side6_q;
    for (int i = 1; i < QB; i++) sided_q[i] <= sided_q[i-1];
    // stage a
    cx_q      <= sat_h ? '1 : qh[CW-1:0];
    cy_q      <= sat_k ? '1 : qk[CW-1:0];
    sat_hk_aq <= sat_h | sat_k;
    big_aq    <= big_h | big_k;
    hs_q      <= qh[SMW-1:0];
    ks_q      <= qk[SMW-1:0];
    ev_q      <= sda.sign_e ? -signed'({1'b0, qe}) : signed'({1'b0, qe});
    ovf_e_aq  <= sda.ovf_e;
    sign_e_aq <= sda.sign_e;
    col_aq    <= sda.col;
    // stage b
    hh_q      <= hs_q * hs_q;
    kk_q      <= ks_q * ks_q;
    cx_bq     <= cx_q;
    cy_bq     <= cy_q;
    sat_hk_bq <= sat_hk_aq;
    big_bq    <= big_aq;
    ev_bq     <= ev_q;
    ovf_e_bq  <= ovf_e_aq;
    sign_e_bq <= sign_e_aq;
    col_bq    <= col_aq;
    // stage c
    rad_q           <= s_c[2*CW-1:0];
    side_c_q.cx     <= cx_bq;
    side_c_q.cy     <= cy_bq;
    side_c_q.sat_hk <= sat_hk_bq;
    side_c_q.r_sat  <= r_sat_c;
    side_c_q.r_zero <= r_zero_c;
    side_c_q.col    <= col_bq;
    // center and radius case ride beside the root stages
    sider_q[0] <= side_c_q;
    for (int i = 1; i < CW; i++) sider_q[i] <= sider_q[i-1];
    // output
    cx_out_q <= sro.cx;
    cy_out_q <= sro.cy;
    r_out_q  <= sro.r_sat ? '1 : (sro.r_zero ? '0 : root);
  end

  cftp_div #(
    .NW (HW),
    .DW (DHW),
    .QB (QB)
  ) u_div_h (
    .clk_i (clk_i),
    .num_i (hnum_q),
    .den_i (hden_q),
    .quo_o (qh)
  );

  cftp_div #(
    .NW (HW),
    .DW (DHW),
    .QB (QB)
  ) u_div_k (
    .clk_i (clk_i),
    .num_i (knum_q),
    .den_i (hden_q),
    .quo_o (qk)
  );

  cftp_div #(
    .NW (NEW),
    .DW (PW),
    .QB (QB)
  ) u_div_e (
    .clk_i (clk_i),
    .num_i (enum_q),
    .den_i (eden_q),
    .quo_o (qe)
  );

  cftp_sqrt #(
    .RW (CW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (rad_q),
    .root_o (root)
  );

  assign done_o      = done_q;
  assign center_x_o  = cx_out_q;
  assign center_y_o  = cy_out_q;
  assign radius_o    = r_out_q;
  assign collinear_o = col_q;
  assign saturated_o = sat_q;

endmodule

[sv/cftp_checker.sv]
// port-level checks for circle_from_three_points, bound to the top level
// depends on cftp_pkg and assert_macros.svh
`include "assert_macros.svh"

module cftp_checker
  import cftp_pkg::*;
#(
  parameter int COORD_WIDTH = DefCoordWidth
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start_i,
  input logic                   busy_o,
  input logic                   done_o,
  input logic [COORD_WIDTH-1:0] center_x_o,
  input logic [COORD_WIDTH-1:0] center_y_o,
  input logic [COORD_WIDTH-1:0] radius_o,
  input logic                   collinear_o,
  input logic                   saturated_o
);

  localparam int Lat = cftp_latency(COORD_WIDTH);
  localparam logic [COORD_WIDTH-1:0] Max = '1;

  // the pipeline takes a transaction every cycle
  `ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy_o)

  // every result traces back to an earlier command, as far back as cftp_latency gives
  `ASSERT_IMPLIES(a_done_after_start, clk_i, rst_ni, done_o, $past(start_i, Lat))

  // flags stay quiet between results
  `ASSERT_IMPLIES(a_flags_idle, clk_i, rst_ni, !done_o, !collinear_o && !saturated_o)

  // saturation always shows as a clipped value
  `ASSERT_IMPLIES(a_sat_clips, clk_i, rst_ni,
                  done_o && center_x_o != Max && center_y_o != Max && radius_o != Max,
                  !saturated_o)

endmodule

bind circle_from_three_points cftp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cftp_checker (.*);
